/* sv/pps_pkg.sv */
// Package for the PSI PAT/PMT section parser: parse phases, result kinds,
// table ids, stream types, descriptor tags and the result record.
// Used by every module in the sv folder; depends on nothing.
package pps_pkg;

    // Parse phase of the section state machine.
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_HEADER    = 4'd1,
        PH_PAT       = 4'd2,
        PH_PMT_FIXED = 4'd3,
        PH_PINFO     = 4'd4,
        PH_ES_HEAD   = 4'd5,
        PH_DESC_TAG  = 4'd6,
        PH_DESC_LEN  = 4'd7,
        PH_DESC_BODY = 4'd8,
        PH_ES_SKIP   = 4'd9,
        PH_DONE      = 4'd10
    } t_phase;

    // Kind of a reported entry.
    typedef enum logic [2:0] {
        KIND_PMT_REF = 3'd0,
        KIND_VIDEO   = 3'd1,
        KIND_AUDIO   = 3'd2,
        KIND_TTX     = 3'd3,
        KIND_SUB     = 3'd4,
        KIND_AC3     = 3'd5
    } t_kind;

    // Table ids.
    localparam logic [7:0] TID_PAT = 8'h00;
    localparam logic [7:0] TID_PMT = 8'h02;

    // Stream types.
    localparam logic [7:0] ST_MPEG1_VIDEO = 8'h01;
    localparam logic [7:0] ST_MPEG2_VIDEO = 8'h02;
    localparam logic [7:0] ST_MPEG1_AUDIO = 8'h03;
    localparam logic [7:0] ST_MPEG2_AUDIO = 8'h04;
    localparam logic [7:0] ST_PRIVATE     = 8'h06;
    localparam logic [7:0] ST_AC3_AUDIO   = 8'h81;

    // Descriptor tags searched in private data loops.
    localparam logic [7:0] TAG_TTX = 8'h56;
    localparam logic [7:0] TAG_SUB = 8'h59;
    localparam logic [7:0] TAG_AC3 = 8'h6a;

    // Bit positions in the found-tag flags.
    localparam int FOUND_TTX = 0;
    localparam int FOUND_SUB = 1;
    localparam int FOUND_AC3 = 2;

    // Shortest section length whose end index (length minus one) is used as the data-region end.
    localparam logic [11:0] MIN_SECTION_LEN = 12'd9;
    // First data byte index, also the empty-region end.
    localparam logic [11:0] DATA_START      = 12'd8;
    // Index of the last header byte.
    localparam logic [11:0] HEADER_LAST     = 12'd7;
    localparam logic [11:0] COUNT_MAX       = 12'hfff;

    // One result transaction.
    typedef struct packed {
        t_kind       kind;
        logic [15:0] program_number;
        logic [12:0] stream_pid;
    } t_result;

endpackage

/* sv/pps_parse.sv */
// Per-byte section state machine of the PSI PAT/PMT parser.
// Holds header fields and entry parse state; produces at most one result
// per accepted byte. Depends on pps_pkg.
module pps_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_section_byte,
    input  logic              i_section_start,
    output logic              o_res_valid,
    output pps_pkg::t_result  o_res
);

    pps_pkg::t_phase r_phase, n_phase;
    logic [11:0] r_byte_count, n_byte_count;
    logic [11:0] r_section_len, n_section_len;
    logic [7:0]  r_table_kind, n_table_kind;
    logic [15:0] r_table_ext, n_table_ext;
    logic [2:0]  r_entry_pos, n_entry_pos;
    logic [15:0] r_entry_word, n_entry_word;
    logic [7:0]  r_entry_type, n_entry_type;
    logic [12:0] r_entry_pid, n_entry_pid;
    logic [11:0] r_skip_rem, n_skip_rem;
    logic [7:0]  r_desc_rem, n_desc_rem;
    logic [2:0]  r_found, n_found;

    logic [11:0] w_end;
    logic [11:0] w_rest;
    logic [15:0] w_word_low;
    logic [11:0] w_skip_min;
    logic [11:0] w_skip_dec;
    logic [7:0]  w_desc_dec;
    logic [2:0]  w_found_len;

    // Kind for a private data stream at the end of its descriptor loop.
    function automatic logic [3:0] loop_kind(input logic [7:0] etype,
                                             input logic [2:0] flags);
        logic [3:0] res;
        res = 4'd0;
        if (etype == pps_pkg::ST_PRIVATE) begin
            if (flags[pps_pkg::FOUND_TTX]) begin
                res = {1'b1, pps_pkg::KIND_TTX};
            end else if (flags[pps_pkg::FOUND_SUB]) begin
                res = {1'b1, pps_pkg::KIND_SUB};
            end else if (flags[pps_pkg::FOUND_AC3]) begin
                res = {1'b1, pps_pkg::KIND_AC3};
            end
        end
        return res;
    endfunction

    // Data region bounds and loop-length clipping.
    always_comb begin
        w_end = (r_section_len >= pps_pkg::MIN_SECTION_LEN) ?
                r_section_len - 12'd1 : pps_pkg::DATA_START;
        w_rest = w_end - r_byte_count - 12'd1;
        w_word_low = {r_entry_word[15:8], i_section_byte};
        w_skip_min = (w_word_low < {4'd0, w_rest}) ? w_word_low[11:0] : w_rest;
        w_skip_dec = r_skip_rem - 12'd1;
        w_desc_dec = r_desc_rem - 8'd1;
        w_found_len = r_found;
        if (r_entry_word == {8'd0, pps_pkg::TAG_TTX}) begin
            w_found_len[pps_pkg::FOUND_TTX] = 1'b1;
        end else if (r_entry_word == {8'd0, pps_pkg::TAG_SUB}) begin
            w_found_len[pps_pkg::FOUND_SUB] = 1'b1;
        end else if (r_entry_word == {8'd0, pps_pkg::TAG_AC3}) begin
            w_found_len[pps_pkg::FOUND_AC3] = 1'b1;
        end
    end

    // Next state and result for the byte on the input.
    always_comb begin
        logic [3:0] fin;
        n_phase       = r_phase;
        n_byte_count  = r_byte_count;
        n_section_len = r_section_len;
        n_table_kind  = r_table_kind;
        n_table_ext   = r_table_ext;
        n_entry_pos   = r_entry_pos;
        n_entry_word  = r_entry_word;
        n_entry_type  = r_entry_type;
        n_entry_pid   = r_entry_pid;
        n_skip_rem    = r_skip_rem;
        n_desc_rem    = r_desc_rem;
        n_found       = r_found;
        o_res_valid   = 1'b0;
        o_res.kind           = pps_pkg::KIND_PMT_REF;
        o_res.program_number = r_table_ext;
        o_res.stream_pid     = r_entry_pid;
        fin = 4'd0;

        if (i_section_start) begin
            // A new section restarts the parse state and takes the table id from its first byte.
            n_phase       = pps_pkg::PH_HEADER;
            n_byte_count  = 12'd1;
            n_section_len = 12'd0;
            n_table_kind  = i_section_byte;
            n_table_ext   = 16'd0;
            n_entry_pos   = 3'd0;
            n_entry_word  = 16'd0;
            n_entry_type  = 8'd0;
            n_entry_pid   = 13'd0;
            n_skip_rem    = 12'd0;
            n_desc_rem    = 8'd0;
            n_found       = 3'd0;
        end else if (r_phase != pps_pkg::PH_IDLE && r_phase != pps_pkg::PH_DONE) begin
            if (r_byte_count != pps_pkg::COUNT_MAX) begin
                n_byte_count = r_byte_count + 12'd1;
            end
            if (r_phase == pps_pkg::PH_HEADER) begin
                // Section length and table id extension, then dispatch on the table id.
                if (r_byte_count == 12'd1) begin
                    n_section_len = {i_section_byte[3:0], 8'd0};
                end else if (r_byte_count == 12'd2) begin
                    n_section_len = {r_section_len[11:8], i_section_byte};
                end else if (r_byte_count == 12'd3) begin
                    n_table_ext = {i_section_byte, 8'd0};
                end else if (r_byte_count == 12'd4) begin
                    n_table_ext = {r_table_ext[15:8], i_section_byte};
                end else if (r_byte_count >= pps_pkg::HEADER_LAST) begin
                    n_entry_pos = 3'd0;
                    if (r_table_kind == pps_pkg::TID_PAT) begin
                        n_phase = pps_pkg::PH_PAT;
                    end else if (r_table_kind == pps_pkg::TID_PMT) begin
                        n_phase = pps_pkg::PH_PMT_FIXED;
                    end else begin
                        n_phase = pps_pkg::PH_DONE;
                    end
                end
            end else if (r_byte_count >= w_end) begin
                n_phase = pps_pkg::PH_DONE;
            end else begin
                case (r_phase)
                    pps_pkg::PH_PAT: begin
                        n_entry_pos = r_entry_pos + 3'd1;
                        case (r_entry_pos)
                            3'd0: n_entry_word = {i_section_byte, 8'd0};
                            3'd1: n_entry_word = w_word_low;
                            3'd2: n_entry_pid = {i_section_byte[4:0], 8'd0};
                            default: begin
                                n_entry_pid = {r_entry_pid[12:8], i_section_byte};
                                n_entry_pos = 3'd0;
                                if (r_entry_word != 16'd0) begin
                                    o_res_valid          = 1'b1;
                                    o_res.kind           = pps_pkg::KIND_PMT_REF;
                                    o_res.program_number = r_entry_word;
                                    o_res.stream_pid     = n_entry_pid;
                                end
                            end
                        endcase
                    end
                    pps_pkg::PH_PMT_FIXED: begin
                        // PCR PID, then program info length.
                        n_entry_pos = r_entry_pos + 3'd1;
                        if (r_entry_pos == 3'd2) begin
                            n_entry_word = {4'd0, i_section_byte[3:0], 8'd0};
                        end else if (r_entry_pos == 3'd3) begin
                            n_entry_word = w_word_low;
                            n_skip_rem   = w_skip_min;
                            n_entry_pos  = 3'd0;
                            n_phase = (w_skip_min != 12'd0) ? pps_pkg::PH_PINFO :
                                      pps_pkg::PH_ES_HEAD;
                        end
                    end
                    pps_pkg::PH_PINFO: begin
                        n_skip_rem = w_skip_dec;
                        if (w_skip_dec == 12'd0) begin
                            n_phase = pps_pkg::PH_ES_HEAD;
                        end
                    end
                    pps_pkg::PH_ES_HEAD: begin
                        n_entry_pos = r_entry_pos + 3'd1;
                        case (r_entry_pos)
                            3'd0: n_entry_type = i_section_byte;
                            3'd1: n_entry_pid = {i_section_byte[4:0], 8'd0};
                            3'd2: n_entry_pid = {r_entry_pid[12:8], i_section_byte};
                            3'd3: n_entry_word = {4'd0, i_section_byte[3:0], 8'd0};
                            default: begin
                                n_entry_word = w_word_low;
                                n_skip_rem   = w_skip_min;
                                n_entry_pos  = 3'd0;
                                n_found      = 3'd0;
                                if (w_skip_min == 12'd0) begin
                                    n_phase = pps_pkg::PH_ES_HEAD;
                                end else if (r_entry_type == pps_pkg::ST_PRIVATE) begin
                                    n_phase = pps_pkg::PH_DESC_TAG;
                                end else begin
                                    n_phase = pps_pkg::PH_ES_SKIP;
                                end
                                if (r_entry_type == pps_pkg::ST_MPEG1_VIDEO ||
                                    r_entry_type == pps_pkg::ST_MPEG2_VIDEO) begin
                                    o_res_valid = 1'b1;
                                    o_res.kind  = pps_pkg::KIND_VIDEO;
                                end else if (r_entry_type == pps_pkg::ST_MPEG1_AUDIO ||
                                             r_entry_type == pps_pkg::ST_MPEG2_AUDIO ||
                                             r_entry_type == pps_pkg::ST_AC3_AUDIO) begin
                                    o_res_valid = 1'b1;
                                    o_res.kind  = pps_pkg::KIND_AUDIO;
                                end
                            end
                        endcase
                    end
                    pps_pkg::PH_DESC_TAG: begin
                        n_entry_word = {8'd0, i_section_byte};
                        n_skip_rem   = w_skip_dec;
                        if (w_skip_dec == 12'd0) begin
                            fin = loop_kind(r_entry_type, r_found);
                        end else begin
                            n_phase = pps_pkg::PH_DESC_LEN;
                        end
                    end
                    pps_pkg::PH_DESC_LEN: begin
                        n_skip_rem = w_skip_dec;
                        if ({4'd0, i_section_byte} > w_skip_dec) begin
                            // Descriptor overruns its loop: stop the search.
                            if (w_skip_dec == 12'd0) begin
                                fin = loop_kind(r_entry_type, r_found);
                            end else begin
                                n_phase = pps_pkg::PH_ES_SKIP;
                            end
                        end else begin
                            n_found    = w_found_len;
                            n_desc_rem = i_section_byte;
                            if (w_skip_dec == 12'd0) begin
                                fin = loop_kind(r_entry_type, w_found_len);
                            end else begin
                                n_phase = (i_section_byte != 8'd0) ?
                                          pps_pkg::PH_DESC_BODY : pps_pkg::PH_DESC_TAG;
                            end
                        end
                    end
                    pps_pkg::PH_DESC_BODY: begin
                        n_skip_rem = w_skip_dec;
                        n_desc_rem = w_desc_dec;
                        if (w_skip_dec == 12'd0) begin
                            fin = loop_kind(r_entry_type, r_found);
                        end else if (w_desc_dec == 8'd0) begin
                            n_phase = pps_pkg::PH_DESC_TAG;
                        end
                    end
                    pps_pkg::PH_ES_SKIP: begin
                        n_skip_rem = w_skip_dec;
                        if (w_skip_dec == 12'd0) begin
                            fin = loop_kind(r_entry_type, r_found);
                        end
                    end
                    default: begin
                        n_phase = pps_pkg::PH_DONE;
                    end
                endcase

                // End of an ES info loop: back to the next entry header.
                if (r_phase != pps_pkg::PH_PAT && r_phase != pps_pkg::PH_PMT_FIXED &&
                    r_phase != pps_pkg::PH_PINFO && r_phase != pps_pkg::PH_ES_HEAD &&
                    n_skip_rem == 12'd0) begin
                    n_phase     = pps_pkg::PH_ES_HEAD;
                    n_entry_pos = 3'd0;
                    if (fin[3]) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = pps_pkg::t_kind'(fin[2:0]);
                    end
                end
            end
        end
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= pps_pkg::PH_IDLE;
            r_byte_count  <= 12'd0;
            r_section_len <= 12'd0;
            r_table_kind  <= 8'd0;
            r_table_ext   <= 16'd0;
            r_entry_pos   <= 3'd0;
            r_entry_word  <= 16'd0;
            r_entry_type  <= 8'd0;
            r_entry_pid   <= 13'd0;
            r_skip_rem    <= 12'd0;
            r_desc_rem    <= 8'd0;
            r_found       <= 3'd0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_byte_count  <= n_byte_count;
            r_section_len <= n_section_len;
            r_table_kind  <= n_table_kind;
            r_table_ext   <= n_table_ext;
            r_entry_pos   <= n_entry_pos;
            r_entry_word  <= n_entry_word;
            r_entry_type  <= n_entry_type;
            r_entry_pid   <= n_entry_pid;
            r_skip_rem    <= n_skip_rem;
            r_desc_rem    <= n_desc_rem;
            r_found       <= n_found;
        end
    end

    // Once a section has started, the parser never falls back to idle.
    a_no_idle_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != pps_pkg::PH_IDLE |=> r_phase != pps_pkg::PH_IDLE)
        else $error("parser returned to idle");

    // Any loop-walking phase has bytes left to consume.
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pps_pkg::PH_PINFO || r_phase == pps_pkg::PH_DESC_TAG ||
         r_phase == pps_pkg::PH_DESC_LEN || r_phase == pps_pkg::PH_DESC_BODY ||
         r_phase == pps_pkg::PH_ES_SKIP) |-> r_skip_rem != 12'd0)
        else $error("loop phase with no bytes left");

    // A descriptor body always has bytes left.
    a_desc_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == pps_pkg::PH_DESC_BODY |-> r_desc_rem != 8'd0)
        else $error("descriptor body with no bytes left");

endmodule

/* sv/pps_outq.sv */
// Two-entry result queue between the parser and the output channel.
// Lets the parser take a byte every cycle while a result waits downstream, as long as the queue is not full.
// Depends on pps_pkg.
module pps_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pps_pkg::t_result  i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output logic              o_full,
    output pps_pkg::t_result  o_data
);

    pps_pkg::t_result r_mem [2];
    logic [1:0] r_count, n_count;
    logic       r_wr_ptr;
    logic       r_rd_ptr;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    // Occupancy after this cycle's push and pop.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // No result is pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != 2'd2)
        else $error("result pushed into full queue");

    // A result pushed without a pop is visible in the next cycle.
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> o_valid)
        else $error("pushed result not visible");

endmodule

/* sv/psi_pat_pmt_section_parser.sv */
// PSI section parser for PAT and PMT tables: one section byte per transaction in,
// program map references and elementary stream entries out.
// A result is written into the result queue as its byte is accepted and is presented once earlier results are taken.
// Throughput: one byte per cycle, set by the per-byte state update; input
// ready drops only when the two-entry result queue is full.
// Reset (synchronous, active low) clears the parse state to idle and empties the queue.
// Depends on pps_pkg, pps_parse and pps_outq.
module psi_pat_pmt_section_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_section_byte,
    input  logic        i_section_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_entry_kind,
    output logic [15:0] o_program_number,
    output logic [12:0] o_stream_pid
);

    logic             w_accept;
    logic             w_res_valid;
    pps_pkg::t_result w_res;
    logic             w_full;
    pps_pkg::t_result w_out;

    // A byte is taken whenever the result queue has room.
    assign o_ready  = ~w_full;
    assign w_accept = i_valid & ~w_full;

    // Section state machine.
    pps_parse u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_section_byte  (i_section_byte),
        .i_section_start (i_section_start),
        .o_res_valid     (w_res_valid),
        .o_res           (w_res)
    );

    // Result queue.
    pps_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept & w_res_valid),
        .i_data  (w_res),
        .i_pop   (o_valid & i_ready),
        .o_valid (o_valid),
        .o_full  (w_full),
        .o_data  (w_out)
    );

    assign o_entry_kind     = w_out.kind;
    assign o_program_number = w_out.program_number;
    assign o_stream_pid     = w_out.stream_pid;

endmodule
